@@ hdl/gped_pkg.sv @@
// shared types and constants for the gamepad deadzone and key edge block
// no dependencies
package gped_pkg;

	localparam int NUM_KEYS = 12;
	localparam int KEY_IDX_W = 4;
	localparam int CFG_W = 15;
	localparam int CFG_IDX_W = 2;
	localparam int SQRT_STEPS = 16;
	localparam int DIV_STEPS = 15;
	localparam int CNT_W = 4;

	localparam logic [CFG_W-1:0] FULL_SCALE = 15'h7fff;
	localparam logic [CFG_W-1:0] DZ_RESET = 15'd7849;
	localparam logic [CFG_W-1:0] TH_RESET = 15'd9000;

	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_THRESH = 2'd1;

	localparam logic KIND_STICK = 1'b0;
	localparam logic KIND_KEY = 1'b1;

	// button word bit for each binding in key order
	localparam logic [3:0] KEY_BIT [NUM_KEYS] = '{
		4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9,
		4'd5, 4'd4, 4'd0, 4'd1, 4'd2, 4'd3
	};

	localparam int BTN_UP = 0;
	localparam int BTN_DOWN = 1;
	localparam int BTN_LEFT = 2;
	localparam int BTN_RIGHT = 3;

	typedef struct packed {
		logic               link_up;
		logic [15:0]        button_word;
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
	} in_word_t;

	typedef struct packed {
		logic                 kind;
		logic [KEY_IDX_W-1:0] key_index;
		logic                 pressed;
		logic signed [15:0]   norm_x;
		logic signed [15:0]   norm_y;
		logic                 last;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic square;
		logic sum;
		logic set_zero;
		logic sqrt_init;
		logic sqrt_step;
		logic rsel;
		logic mul1;
		logic mul2;
		logic div_step;
		logic emit_report;
		logic emit_key;
		logic key_next;
	} cmd_t;

	typedef struct packed {
		logic link;
		logic in_dz;
		logic out_free;
		logic diff_empty;
		logic key_hit;
	} sts_t;

endpackage

@@ hdl/gamepad_edge_events_deadzone.sv @@
// top level: config registers, sequencer and datapath for the gamepad poll block
// depends on gped_pkg, gped_ctrl, gped_dp
// a stick word outside the deadzone passes squares, sum, check, a 16-step root, range select,
// scale products and 15-step dividers for both axes; a link-down sample goes straight to the
// report, a deadzone one after squares, sum and check; the key scan then steps through the
// bindings up to the last changed one, stalling while the output is full; a new sample is taken only when idle
// reset clears held keys and link state, empties the output, loads 7849 and 9000 into config
module gamepad_edge_events_deadzone (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  gped_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output gped_pkg::out_word_t            out_data,
	input  logic                           cfg_we,
	input  logic [gped_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gped_pkg::CFG_W-1:0]     cfg_data
);
	import gped_pkg::*;

	logic [CFG_W-1:0] dz_q, th_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= DZ_RESET;
			th_q <= TH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_DEAD_ZONE) dz_q <= cfg_data;
			else if (cfg_index == REG_DIR_THRESH) th_q <= cfg_data;
		end
	end

	gped_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gped_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_data             (in_data),
		.dead_zone           (dz_q),
		.direction_threshold (th_q),
		.cmd                 (cmd),
		.sts                 (sts),
		.out_ready           (out_ready),
		.out_valid           (out_valid),
		.out_data            (out_data)
	);

endmodule

@@ hdl/gped_ctrl.sv @@
// sequencer for one poll sample: squares, root, scale, divide, report, key scan
// depends on gped_pkg
module gped_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gped_pkg::sts_t sts,
	output gped_pkg::cmd_t cmd
);
	import gped_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SQUARE, S_SUM, S_CHECK, S_SQRT, S_RSEL,
		S_MUL1, S_MUL2, S_DIV, S_REPORT, S_KEYS
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid;
			S_SQUARE: cmd.square = 1'b1;
			S_SUM:    cmd.sum = 1'b1;
			S_CHECK: begin
				cmd.set_zero = sts.in_dz;
				cmd.sqrt_init = !sts.in_dz;
			end
			S_SQRT:   cmd.sqrt_step = 1'b1;
			S_RSEL:   cmd.rsel = 1'b1;
			S_MUL1:   cmd.mul1 = 1'b1;
			S_MUL2:   cmd.mul2 = 1'b1;
			S_DIV:    cmd.div_step = 1'b1;
			S_REPORT: cmd.emit_report = sts.out_free;
			S_KEYS: begin
				cmd.emit_key = !sts.diff_empty && sts.key_hit && sts.out_free;
				cmd.key_next = !sts.diff_empty && !sts.key_hit;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= sts.link ? S_SQUARE : S_REPORT;
					end
				end
				S_SQUARE: state_q <= S_SUM;
				S_SUM:    state_q <= S_CHECK;
				S_CHECK: begin
					cnt_q <= '0;
					state_q <= sts.in_dz ? S_REPORT : S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						state_q <= S_RSEL;
					end
				end
				S_RSEL: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (sts.out_free) begin
						state_q <= S_KEYS;
					end
				end
				S_KEYS: begin
					if (sts.diff_empty) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsel |-> $past(cmd.sqrt_step, SQRT_STEPS))
		else $error("root ran short");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && cnt_q == '0 |-> $past(cmd.mul2))
		else $error("divide started without operands");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("accepted a second sample during work");

endmodule

@@ hdl/gped_dp.sv @@
// datapath: clamp, squares, bitwise root, scale products, dividers, key diff, output word
// depends on gped_pkg
module gped_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gped_pkg::in_word_t         in_data,
	input  logic [gped_pkg::CFG_W-1:0] dead_zone,
	input  logic [gped_pkg::CFG_W-1:0] direction_threshold,
	input  gped_pkg::cmd_t             cmd,
	output gped_pkg::sts_t             sts,
	input  logic                       out_ready,
	output logic                       out_valid,
	output gped_pkg::out_word_t        out_data
);
	import gped_pkg::*;

	logic               zero_q, neg_x_q, neg_y_q;
	logic [14:0]        mag_x_q, mag_y_q;
	logic [29:0]        sq_x_q, sq_y_q, dzsq_q;
	logic [30:0]        s_q;
	logic [30:0]        rem_q, bit_q;
	logic [31:0]        res_q;
	logic [14:0]        r_q, span_q;
	logic [29:0]        px_q, py_q;
	logic [30:0]        den_q;
	logic [44:0]        rx_q, ry_q, dsh_q;
	logic [14:0]        qx_q, qy_q;
	logic [NUM_KEYS-1:0] held_q, diff_q;
	logic               conn_q;
	logic [KEY_IDX_W-1:0] idx_q;
	logic               out_valid_q;
	out_word_t          out_q;

	// sample decode
	logic [15:0]         cx, cy, ax, ay;
	logic signed [16:0]  th_s, raw_x, raw_y;
	logic [15:0]         btn;
	logic [NUM_KEYS-1:0] now;
	logic                go_left, go_down;

	always_comb begin
		cx = (in_data.stick_x == 16'sh8000) ? 16'h8001 : in_data.stick_x;
		cy = (in_data.stick_y == 16'sh8000) ? 16'h8001 : in_data.stick_y;
		ax = cx[15] ? 16'h0000 - cx : cx;
		ay = cy[15] ? 16'h0000 - cy : cy;
		th_s = signed'({2'b00, direction_threshold});
		raw_x = 17'(in_data.stick_x);
		raw_y = 17'(in_data.stick_y);
		go_left = raw_x < -th_s;
		go_down = raw_y < -th_s;
		btn = in_data.button_word;
		if (go_left) btn[BTN_LEFT] = 1'b1;
		else if (raw_x > th_s) btn[BTN_RIGHT] = 1'b1;
		if (go_down) btn[BTN_DOWN] = 1'b1;
		else if (raw_y > th_s) btn[BTN_UP] = 1'b1;
		for (int i = 0; i < NUM_KEYS; i++) begin
			now[i] = btn[KEY_BIT[i]];
		end
	end

	// root step
	logic [31:0] sq_try;
	logic        sq_take;
	assign sq_try = res_q + {1'b0, bit_q};
	assign sq_take = {1'b0, rem_q} >= sq_try;

	// scale radius
	logic [15:0] m, m_dz;
	logic [14:0] span;
	assign m = res_q[15:0];
	assign m_dz = m - {1'b0, dead_zone};
	assign span = FULL_SCALE - dead_zone;

	// divider step
	logic take_x, take_y;
	assign take_x = rx_q >= dsh_q;
	assign take_y = ry_q >= dsh_q;

	// next output word
	out_word_t out_next;

	always_comb begin
		out_next = '0;
		if (cmd.emit_report) begin
			out_next.kind = KIND_STICK;
			if (!zero_q) begin
				out_next.norm_x = neg_x_q ? -signed'({1'b0, qx_q}) : signed'({1'b0, qx_q});
				out_next.norm_y = neg_y_q ? -signed'({1'b0, qy_q}) : signed'({1'b0, qy_q});
			end
			out_next.last = (diff_q == '0);
		end else begin
			out_next.kind = KIND_KEY;
			out_next.key_index = idx_q;
			out_next.pressed = held_q[idx_q];
			out_next.last = ((diff_q & ~(NUM_KEYS'(1) << idx_q)) == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zero_q <= !in_data.link_up;
			neg_x_q <= cx[15];
			neg_y_q <= cy[15];
			mag_x_q <= ax[14:0];
			mag_y_q <= ay[14:0];
		end
		if (cmd.square) begin
			sq_x_q <= 30'(mag_x_q) * 30'(mag_x_q);
			sq_y_q <= 30'(mag_y_q) * 30'(mag_y_q);
			dzsq_q <= 30'(dead_zone) * 30'(dead_zone);
		end
		if (cmd.sum) begin
			s_q <= 31'(sq_x_q) + 31'(sq_y_q);
		end
		if (cmd.set_zero) begin
			zero_q <= 1'b1;
		end
		if (cmd.sqrt_init) begin
			zero_q <= 1'b0;
			rem_q <= s_q;
			res_q <= '0;
			bit_q <= 31'h4000_0000;
		end
		if (cmd.sqrt_step) begin
			if (sq_take) begin
				rem_q <= rem_q - sq_try[30:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.rsel) begin
			r_q <= (m_dz > {1'b0, span}) ? span : m_dz[14:0];
			span_q <= span;
		end
		if (cmd.mul1) begin
			px_q <= 30'(mag_x_q) * 30'(r_q);
			py_q <= 30'(mag_y_q) * 30'(r_q);
			den_q <= 31'(m) * 31'(span_q);
		end
		if (cmd.mul2) begin
			rx_q <= {px_q, 15'b0} - 45'(px_q);
			ry_q <= {py_q, 15'b0} - 45'(py_q);
			dsh_q <= {den_q, 14'b0};
			qx_q <= '0;
			qy_q <= '0;
		end
		if (cmd.div_step) begin
			if (take_x) rx_q <= rx_q - dsh_q;
			if (take_y) ry_q <= ry_q - dsh_q;
			qx_q <= {qx_q[13:0], take_x};
			qy_q <= {qy_q[13:0], take_y};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.emit_report || cmd.emit_key) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			diff_q <= '0;
			conn_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				conn_q <= in_data.link_up;
				if (in_data.link_up) begin
					diff_q <= held_q ^ now;
					held_q <= now;
				end else begin
					diff_q <= conn_q ? held_q : '0;
					held_q <= '0;
				end
			end
			if (cmd.emit_key) begin
				diff_q[idx_q] <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.key_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.emit_report || cmd.emit_key) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.link = in_data.link_up;
		sts.in_dz = (dead_zone == FULL_SCALE) || (31'(dzsq_q) >= s_q);
		sts.out_free = !out_valid_q || out_ready;
		sts.diff_empty = (diff_q == '0);
		sts.key_hit = diff_q[idx_q];
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_report || cmd.emit_key) |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");
	a_key_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_key |-> diff_q[idx_q])
		else $error("event for an unchanged key");
	a_key_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_key |=> $countones(diff_q) == $past($countones(diff_q)) - 1)
		else $error("key change not retired");
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsel |-> m >= {1'b0, dead_zone})
		else $error("root below deadzone");

endmodule
